FILE: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
        else $error("assertion failed");

`endif

FILE: hdl/fdt_pkg.sv
package fdt_pkg;

    localparam int CFG_W               = 4;
    localparam int IPART_W             = 31;
    localparam int FV_W                = 30;
    localparam int MANT_W              = 24;
    localparam int PROD_W              = 54;
    localparam int SH_W                = 8;
    localparam int INT_DIGITS          = 10;
    localparam int DEF_MAX_FRAC_DIGITS = 9;
    localparam int CONV_STEPS          = 31;

    localparam logic [CFG_W-1:0] FRAC_RESET = 4'd4;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_DOT  = 8'h2E;
    localparam logic [7:0] CHAR_NUL  = 8'h00;

    typedef struct packed {
        logic               err;
        logic [IPART_W-1:0] ipart;
        logic [FV_W-1:0]    fv;
        logic [CFG_W-1:0]   k;
    } t_job;

    typedef struct packed {
        logic push;
        logic full;
    } t_wr_side;

    typedef struct packed {
        logic pop;
        logic empty;
    } t_rd_side;

    function automatic logic [FV_W-1:0] pow10(input logic [CFG_W-1:0] k);
        logic [FV_W-1:0] p;
        case (k)
            4'd0:    p = 30'd1;
            4'd1:    p = 30'd10;
            4'd2:    p = 30'd100;
            4'd3:    p = 30'd1000;
            4'd4:    p = 30'd10000;
            4'd5:    p = 30'd100000;
            4'd6:    p = 30'd1000000;
            4'd7:    p = 30'd10000000;
            4'd8:    p = 30'd100000000;
            4'd9:    p = 30'd1000000000;
            default: p = 30'd1;
        endcase
        return p;
    endfunction

endpackage

FILE: hdl/float_to_decimal_text.sv
// float_to_decimal_text: formats one IEEE single-precision value as fixed
// decimal ASCII text, one character per output transfer, ending with NUL.
// Input channel: i_in_valid / o_in_stall carry i_value_bits; a transfer
// happens when valid is high and stall is low.
// Output channel: o_out_valid / i_out_stall carry o_char_code, o_last_char
// (set on the NUL) and o_range_error (set on the lone NUL of a negative,
// NaN, infinite or >= 2^31 input).
// Config channel: i_cfg_valid / o_cfg_ready write i_cfg_frac_digits, the
// count of fraction digits (values above the maximum saturate).
// The front takes a new value only once it has pushed the last one into a
// two-entry queue. The back runs a 31-step binary-to-BCD conversion, one
// step per cycle, then emits one character per cycle while the output is not
// stalled: N characters (at most 21) per item, or the NUL alone on an error.
// A stalled output holds its character; the back waits, the queue fills,
// then the front stalls its input.
// Reset clears all control state and sets frac_digits to 4.
module float_to_decimal_text #(
    parameter int MAX_FRAC_DIGITS = fdt_pkg::DEF_MAX_FRAC_DIGITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [31:0]               i_value_bits,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [7:0]                o_char_code,
    output logic                      o_last_char,
    output logic                      o_range_error,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [fdt_pkg::CFG_W-1:0] i_cfg_frac_digits
);

`include "assert_macros.svh"

    logic [fdt_pkg::CFG_W-1:0] r_frac_digits;
    fdt_pkg::t_job    w_fjob, w_qjob;
    fdt_pkg::t_wr_side w_wr;
    fdt_pkg::t_rd_side w_rd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac_digits <= fdt_pkg::FRAC_RESET;
        end else if (i_cfg_valid) begin
            r_frac_digits <= i_cfg_frac_digits;
        end
    end

    fdt_front #(.MAX_FRAC_DIGITS(MAX_FRAC_DIGITS)) u_front (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .i_value_bits,
        .i_frac_digits(r_frac_digits), .i_full(w_wr.full), .o_push(w_wr.push),
        .o_job(w_fjob)
    );

    fdt_queue u_queue (
        .i_clk, .i_rst_n, .i_job(w_fjob), .i_push(w_wr.push), .o_full(w_wr.full),
        .i_pop(w_rd.pop), .o_empty(w_rd.empty), .o_job(w_qjob)
    );

    fdt_back #(.MAX_FRAC_DIGITS(MAX_FRAC_DIGITS)) u_back (
        .i_clk, .i_rst_n, .i_empty(w_rd.empty), .o_pop(w_rd.pop), .i_job(w_qjob),
        .o_out_valid, .i_out_stall, .o_char_code, .o_last_char, .o_range_error
    );

    `ASSERT_IMPLIES(a_last_is_nul, i_clk, i_rst_n, o_out_valid && o_last_char, o_char_code == 8'h00)
    `ASSERT_IMPLIES(a_err_on_last, i_clk, i_rst_n, o_out_valid && o_range_error, o_last_char)
    `ASSERT_IMPLIES(a_text_nonnul, i_clk, i_rst_n, o_out_valid && !o_last_char, o_char_code != 8'h00)
    `ASSERT_NEXT(a_no_push_full, i_clk, i_rst_n, w_wr.full && !w_rd.pop, w_wr.full)

endmodule

FILE: hdl/fdt_front.sv
module fdt_front #(
    parameter int MAX_FRAC_DIGITS = fdt_pkg::DEF_MAX_FRAC_DIGITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [31:0]                 i_value_bits,
    input  logic [fdt_pkg::CFG_W-1:0]   i_frac_digits,
    input  logic                        i_full,
    output logic                        o_push,
    output fdt_pkg::t_job               o_job
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MUL  = 2'd1;
    localparam logic [1:0] F_SHF  = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_err;
    logic [fdt_pkg::IPART_W-1:0] r_ipart;
    logic [fdt_pkg::CFG_W-1:0]   r_k;
    logic [fdt_pkg::MANT_W-1:0]  r_f;
    logic [fdt_pkg::SH_W-1:0]    r_sh;
    logic [fdt_pkg::FV_W-1:0]    r_p10;
    logic [fdt_pkg::PROD_W-1:0]  r_prod;

    logic [7:0]                  w_exp;
    logic [8:0]                  w_e;
    logic [fdt_pkg::MANT_W-1:0]  w_mant, w_f;
    logic [fdt_pkg::SH_W-1:0]    w_sh;
    logic [2:0]                  w_lsh;
    logic [fdt_pkg::IPART_W-1:0] w_ipart;
    logic                        w_err;
    logic [fdt_pkg::CFG_W-1:0]   w_k;
    logic [fdt_pkg::FV_W-1:0]    w_fv;
    logic                        w_acc;

    assign o_in_stall = (r_state != F_IDLE);
    assign w_acc      = i_in_valid && (r_state == F_IDLE);

    always_comb begin
        w_exp  = i_value_bits[30:23];
        w_e    = (w_exp == 8'd0) ? 9'd1 : {1'b0, w_exp};
        w_mant = {(w_exp != 8'd0), i_value_bits[22:0]};
        w_err  = (i_value_bits[31] && (i_value_bits[30:0] != 31'd0)) || (w_exp >= 8'd158);
        w_k    = (i_frac_digits > fdt_pkg::CFG_W'(MAX_FRAC_DIGITS)) ?
                 fdt_pkg::CFG_W'(MAX_FRAC_DIGITS) : i_frac_digits;
        w_lsh  = 3'd0;
        w_sh   = '0;
        w_f    = '0;
        if (w_e >= 9'd150) begin
            w_lsh   = 3'(w_e - 9'd150);
            w_ipart = fdt_pkg::IPART_W'({7'd0, w_mant} << w_lsh);
        end else begin
            w_sh = fdt_pkg::SH_W'(9'd150 - w_e);
            if (w_sh >= 8'd24) begin
                w_ipart = '0;
                w_f     = w_mant;
            end else begin
                w_ipart = fdt_pkg::IPART_W'(w_mant >> w_sh);
                w_f     = w_mant & ((fdt_pkg::MANT_W'(1) << w_sh) - fdt_pkg::MANT_W'(1));
            end
        end
    end

    assign w_fv = (r_sh >= 8'd54) ? '0 : fdt_pkg::FV_W'(r_prod >> r_sh);

    always_comb begin
        n_state = r_state;
        o_push  = 1'b0;
        case (r_state)
            F_IDLE: if (w_acc) n_state = F_MUL;
            F_MUL:  n_state = F_SHF;
            F_SHF: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    assign o_job = '{err: r_err, ipart: r_ipart, fv: w_fv, k: r_k};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (w_acc) begin
            r_err   <= w_err;
            r_ipart <= w_ipart;
            r_k     <= w_k;
            r_f     <= w_f;
            r_sh    <= w_sh;
            r_p10   <= fdt_pkg::pow10(w_k);
        end
        if (r_state == F_MUL) begin
            r_prod <= r_f * r_p10;
        end
    end

endmodule

FILE: hdl/fdt_queue.sv
module fdt_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fdt_pkg::t_job     i_job,
    input  logic              i_push,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output fdt_pkg::t_job     o_job
);

    fdt_pkg::t_job r_mem [2];
    logic          r_wr, r_rd;
    logic [1:0]    r_cnt;
    logic          w_push, w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wr <= !r_wr;
            if (w_pop)  r_rd <= !r_rd;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
        if (w_push) r_mem[r_wr] <= i_job;
    end

endmodule

FILE: hdl/fdt_back.sv
module fdt_back #(
    parameter int MAX_FRAC_DIGITS = fdt_pkg::DEF_MAX_FRAC_DIGITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    output logic              o_pop,
    input  fdt_pkg::t_job     i_job,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_char_code,
    output logic              o_last_char,
    output logic              o_range_error
);

    localparam int IBW = 4 * fdt_pkg::INT_DIGITS;
    localparam int FBW = 4 * MAX_FRAC_DIGITS;

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_CONV = 2'd1;
    localparam logic [1:0] B_EMIT = 2'd2;

    localparam logic [2:0] P_START = 3'd0;
    localparam logic [2:0] P_INT   = 3'd1;
    localparam logic [2:0] P_DOT   = 3'd2;
    localparam logic [2:0] P_FRAC  = 3'd3;
    localparam logic [2:0] P_NUL   = 3'd4;

    logic [1:0] r_state;
    logic [2:0] r_phase;
    logic [4:0] r_cnt;
    logic [3:0] r_idx;
    logic       r_err;
    logic [fdt_pkg::CFG_W-1:0]   r_k;
    logic [fdt_pkg::IPART_W-1:0] r_bin_i, r_bin_f;
    logic [IBW-1:0]              r_bcd_i;
    logic [FBW-1:0]              r_bcd_f;
    logic                        r_out_valid, r_last, r_rerr;
    logic [7:0]                  r_char;

    logic [IBW-1:0] w_adj_i;
    logic [FBW-1:0] w_adj_f;
    logic [3:0]     w_len, w_dig_i, w_dig_f;
    logic           w_adv;
    logic           w_emit;

    always_comb begin
        w_adj_i = r_bcd_i;
        for (int j = 0; j < fdt_pkg::INT_DIGITS; j++) begin
            if (r_bcd_i[4*j +: 4] >= 4'd5) w_adj_i[4*j +: 4] = r_bcd_i[4*j +: 4] + 4'd3;
        end
        w_adj_f = r_bcd_f;
        for (int j = 0; j < MAX_FRAC_DIGITS; j++) begin
            if (r_bcd_f[4*j +: 4] >= 4'd5) w_adj_f[4*j +: 4] = r_bcd_f[4*j +: 4] + 4'd3;
        end
        w_len = 4'd0;
        for (int j = 0; j < fdt_pkg::INT_DIGITS; j++) begin
            if (r_bcd_i[4*j +: 4] != 4'd0) w_len = 4'(j + 1);
        end
        w_dig_i = 4'd0;
        for (int j = 0; j < fdt_pkg::INT_DIGITS; j++) begin
            if (r_idx == 4'(j)) w_dig_i = r_bcd_i[4*j +: 4];
        end
        w_dig_f = 4'd0;
        for (int j = 0; j < MAX_FRAC_DIGITS; j++) begin
            if (r_idx == 4'(j)) w_dig_f = r_bcd_f[4*j +: 4];
        end
    end

    assign w_adv  = !r_out_valid || !i_out_stall;
    assign w_emit = (r_state == B_EMIT) && (r_phase != P_START) && w_adv;
    assign o_pop  = (r_state == B_IDLE) && !i_empty;

    assign o_out_valid   = r_out_valid;
    assign o_char_code   = r_char;
    assign o_last_char   = r_last;
    assign o_range_error = r_rerr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_phase     <= P_START;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv && !w_emit) r_out_valid <= 1'b0;
            case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_err   <= i_job.err;
                        r_k     <= i_job.k;
                        r_bin_i <= i_job.ipart;
                        r_bin_f <= {1'b0, i_job.fv};
                        r_bcd_i <= '0;
                        r_bcd_f <= '0;
                        r_cnt   <= 5'd0;
                        if (i_job.err) begin
                            r_phase <= P_NUL;
                            r_state <= B_EMIT;
                        end else begin
                            r_phase <= P_START;
                            r_state <= B_CONV;
                        end
                    end
                end
                B_CONV: begin
                    r_bcd_i <= {w_adj_i[IBW-2:0], r_bin_i[fdt_pkg::IPART_W-1]};
                    r_bcd_f <= {w_adj_f[FBW-2:0], r_bin_f[fdt_pkg::IPART_W-1]};
                    r_bin_i <= {r_bin_i[fdt_pkg::IPART_W-2:0], 1'b0};
                    r_bin_f <= {r_bin_f[fdt_pkg::IPART_W-2:0], 1'b0};
                    r_cnt   <= r_cnt + 5'd1;
                    if (r_cnt == 5'(fdt_pkg::CONV_STEPS - 1)) r_state <= B_EMIT;
                end
                B_EMIT: begin
                    if (r_phase == P_START) begin
                        if (w_len != 4'd0) begin
                            r_phase <= P_INT;
                            r_idx   <= w_len - 4'd1;
                        end else if (r_k != 4'd0) begin
                            r_phase <= P_DOT;
                        end else begin
                            r_phase <= P_NUL;
                        end
                    end else if (w_adv) begin
                        r_out_valid <= 1'b1;
                        r_last      <= 1'b0;
                        r_rerr      <= 1'b0;
                        case (r_phase)
                            P_INT: begin
                                r_char <= fdt_pkg::CHAR_ZERO + {4'd0, w_dig_i};
                                if (r_idx == 4'd0) r_phase <= (r_k != 4'd0) ? P_DOT : P_NUL;
                                else r_idx <= r_idx - 4'd1;
                            end
                            P_DOT: begin
                                r_char  <= fdt_pkg::CHAR_DOT;
                                r_phase <= P_FRAC;
                                r_idx   <= r_k - 4'd1;
                            end
                            P_FRAC: begin
                                r_char <= fdt_pkg::CHAR_ZERO + {4'd0, w_dig_f};
                                if (r_idx == 4'd0) r_phase <= P_NUL;
                                else r_idx <= r_idx - 4'd1;
                            end
                            default: begin
                                r_char  <= fdt_pkg::CHAR_NUL;
                                r_last  <= 1'b1;
                                r_rerr  <= r_err;
                                r_state <= B_IDLE;
                            end
                        endcase
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule
